// ===== hw/rtl/opbi_pkg.sv =====
package opbi_pkg;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_WORDS = 2'd1;
    localparam logic [1:0] CFG_BITS  = 2'd2;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    localparam int STORE_W = 8;

    typedef struct packed {
        logic       mode;
        logic [3:0] wc_m1;
        logic [2:0] db;
        logic [2:0] db_m1;
    } cfg_t;

    typedef struct packed {
        logic [3:0] word;
        logic [2:0] pos;
        logic       bit_val;
        logic       blk_end;
    } q_item_t;

endpackage

// ===== hw/rtl/opbi_front.sv =====
module opbi_front
    import opbi_pkg::*;
#(
    parameter int WIDX = 3
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cfg_clear,
    input  logic    start,
    input  logic    bit_in,
    input  logic    q_full,
    output logic    busy,
    output logic    push,
    output q_item_t push_item
);

    logic [WIDX-1:0] w_reg;
    logic [WIDX-1:0] w_next;
    logic [2:0]      pos_reg;
    logic [2:0]      pos_next;
    logic            w_last;
    logic            blk_end;

    assign busy   = q_full;
    assign push   = start && !q_full;
    assign w_last = (w_reg == cfg.wc_m1[WIDX-1:0]);

    always_comb
    begin
        w_next   = w_reg;
        pos_next = pos_reg;
        if (cfg.mode == MODE_SEND)
        begin
            blk_end = w_last && (pos_reg == cfg.db_m1);
            if (pos_reg == cfg.db_m1)
            begin
                pos_next = '0;
                w_next   = w_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        else
        begin
            blk_end = w_last && (pos_reg == cfg.db);
            if (w_last)
            begin
                w_next   = '0;
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                w_next = w_reg + 1'b1;
            end
        end
        if (blk_end)
        begin
            w_next   = '0;
            pos_next = '0;
        end
    end

    assign push_item.word    = 4'(w_reg);
    assign push_item.pos     = pos_reg;
    assign push_item.bit_val = bit_in;
    assign push_item.blk_end = blk_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= '0;
            pos_reg <= '0;
        end
        else if (cfg_clear)
        begin
            w_reg   <= '0;
            pos_reg <= '0;
        end
        else if (push)
        begin
            w_reg   <= w_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/opbi_queue.sv =====
module opbi_queue
    import opbi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output logic    empty,
    output logic    full,
    output q_item_t head
);

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/opbi_back.sv =====
module opbi_back
    import opbi_pkg::*;
#(
    parameter int WORDS_MAX = 8,
    parameter int WIDX      = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  q_item_t    head,
    output logic       pop,
    output logic       out_valid,
    output logic       bit_out,
    output logic [7:0] word_value,
    output logic       parity_error,
    output logic       last
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic [STORE_W-1:0] store_reg [WORDS_MAX];
    logic               state_reg;
    logic               state_next;
    logic [WIDX-1:0]    j_reg;
    logic [WIDX-1:0]    j_next;
    logic [2:0]         i_reg;
    logic [2:0]         i_next;
    logic               out_valid_reg;
    logic               bit_out_reg;
    logic [7:0]         word_value_reg;
    logic               parity_error_reg;
    logic               last_reg;

    logic [STORE_W-1:0] entry;
    logic [STORE_W-1:0] mask_data;
    logic [STORE_W-1:0] mask_full;
    logic               odd_par;
    logic               even_full;
    logic [7:0]         rev_word;
    logic               j_last;
    logic               emit_last;
    logic               emit_bit;

    assign entry     = store_reg[j_reg];
    assign mask_data = STORE_W'((9'd1 << cfg.db) - 9'd1);
    assign mask_full = STORE_W'((9'd1 << (4'(cfg.db) + 4'd1)) - 9'd1);
    assign odd_par   = ~^(entry & mask_data);
    assign even_full = ~^(entry & mask_full);
    assign j_last    = (j_reg == cfg.wc_m1[WIDX-1:0]);
    assign emit_bit  = (i_reg == cfg.db) ? odd_par : entry[i_reg];
    assign emit_last = (cfg.mode == MODE_SEND) ? (j_last && (i_reg == cfg.db)) : j_last;
    assign pop       = (state_reg == ST_LOAD) && !q_empty;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            if (3'(k) <= cfg.db)
            begin
                rev_word[k] = entry[3'(cfg.db - 3'(k))];
            end
            else
            begin
                rev_word[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (pop && head.blk_end)
                begin
                    state_next = ST_EMIT;
                    j_next     = '0;
                    i_next     = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_LOAD;
                end
                else if (j_last)
                begin
                    j_next = '0;
                    i_next = i_reg + 3'd1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store_reg[head.word[WIDX-1:0]][head.pos] <= head.bit_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            if (cfg.mode == MODE_SEND)
            begin
                bit_out_reg      <= emit_bit;
                word_value_reg   <= '0;
                parity_error_reg <= 1'b0;
            end
            else
            begin
                bit_out_reg      <= 1'b0;
                word_value_reg   <= rev_word;
                parity_error_reg <= even_full;
            end
            last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            j_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            out_valid_reg <= (state_reg == ST_EMIT);
        end
    end

    assign out_valid    = out_valid_reg;
    assign bit_out      = bit_out_reg;
    assign word_value   = word_value_reg;
    assign parity_error = parity_error_reg;
    assign last         = last_reg;

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $past(state_reg == ST_EMIT))
        else $error("result without emit phase");

    a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !pop)
        else $error("queue popped during emit");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (state_reg == ST_LOAD))
        else $error("emit continues after last item");

endmodule

// ===== hw/rtl/odd_parity_block_interleaver.sv =====
// Serial odd-parity block interleaver. Send mode takes word_count words of data_bits bits,
// row by row, one bit per item, and then emits word_count*(data_bits+1) bits in column order
// with an odd parity bit per word as the last column. Receive mode takes such a column-order
// stream and, after the last bit, emits one item per word with the rebuilt word (first bit
// most significant, parity last) and parity_error set on even parity. Items are accepted one
// per cycle into a two-entry queue in front of the bit store; busy rises when that queue is
// full. Once a block is complete the store is read out one result per cycle, and no new bit
// enters the store meanwhile. Each result is on the ports for one cycle with out_valid high
// and cannot be held off; last marks the final result of a block. Configuration writes are
// taken at any time (cfg_ready is always high), belong only to idle periods, and, for the
// three defined register indices, restart block loading.
module odd_parity_block_interleaver
    import opbi_pkg::*;
#(
    parameter int WORDS_MAX = 8,
    parameter int BITS_MAX  = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       bit_in,
    output logic       out_valid,
    output logic       bit_out,
    output logic [7:0] word_value,
    output logic       parity_error,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int WIDX = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;

    logic       mode_reg;
    logic [3:0] word_count_reg;
    logic [2:0] data_bits_reg;
    logic [3:0] eff_words;
    logic [2:0] eff_bits;
    logic       cfg_clear;
    cfg_t       cfg;
    logic       push;
    q_item_t    push_item;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    q_item_t    head;

    assign cfg_ready = 1'b1;
    assign cfg_clear = cfg_valid && (cfg_index <= CFG_BITS);

    always_comb
    begin
        priority if (word_count_reg == 4'd0)
        begin
            eff_words = 4'd1;
        end
        else if (32'(word_count_reg) > WORDS_MAX)
        begin
            eff_words = 4'(WORDS_MAX);
        end
        else
        begin
            eff_words = word_count_reg;
        end
        priority if (data_bits_reg == 3'd0)
        begin
            eff_bits = 3'd1;
        end
        else if (32'(data_bits_reg) > BITS_MAX)
        begin
            eff_bits = 3'(BITS_MAX);
        end
        else
        begin
            eff_bits = data_bits_reg;
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.wc_m1 = eff_words - 4'd1;
    assign cfg.db    = eff_bits;
    assign cfg.db_m1 = eff_bits - 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SEND;
            word_count_reg <= 4'd8;
            data_bits_reg  <= 3'd7;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg       <= cfg_data[0];
                CFG_WORDS: word_count_reg <= cfg_data;
                CFG_BITS:  data_bits_reg  <= cfg_data[2:0];
                default:   ;
            endcase
        end
    end

    opbi_front #(
        .WIDX(WIDX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_clear(cfg_clear),
        .start    (start),
        .bit_in   (bit_in),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .push_item(push_item)
    );

    opbi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .empty    (q_empty),
        .full     (q_full),
        .head     (head)
    );

    opbi_back #(
        .WORDS_MAX(WORDS_MAX),
        .WIDX     (WIDX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .bit_out     (bit_out),
        .word_value  (word_value),
        .parity_error(parity_error),
        .last        (last)
    );

endmodule

// ===== verif/opbi_monitor.sv =====
module opbi_monitor
    import opbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       bit_in,
    input  logic       out_valid,
    input  logic       bit_out,
    input  logic [7:0] word_value,
    input  logic       parity_error,
    input  logic       last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output int         failures,
    output int         waiting,
    output int         checked
);

    typedef struct packed {
        logic       bit_out;
        logic [7:0] word_value;
        logic       parity_error;
        logic       last;
    } block_out_t;

    block_out_t block_out_q[$];
    block_out_t want;
    block_out_t got;

    logic       mode_reg;
    logic [3:0] words_reg;
    logic [2:0] bits_reg;
    logic [7:0] row_store [8];
    int         bit_cnt;

    int         wc;
    int         db;
    int         len;
    int         total;
    int         row;
    int         col;
    logic       par;
    logic [7:0] word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  = MODE_SEND;
            words_reg = 4'd8;
            bits_reg  = 3'd7;
            bit_cnt   = 0;
            for (int k = 0; k < 8; k++)
            begin
                row_store[k] = '0;
            end
            block_out_q.delete();
            failures = 0;
            waiting  = 0;
            checked  = 0;
        end
        else
        begin
            if (out_valid)
            begin
                got = '{bit_out, word_value, parity_error, last};
                if (block_out_q.size() == 0)
                begin
                    $error("unexpected item: bit_out %0d word_value 0x%02h parity_error %0d last %0d",
                           bit_out, word_value, parity_error, last);
                    failures++;
                end
                else
                begin
                    want = block_out_q.pop_front();
                    checked++;
                    if (got.bit_out !== want.bit_out)
                    begin
                        $error("bit_out mismatch: expected %0d, got %0d",
                               want.bit_out, got.bit_out);
                        failures++;
                    end
                    if (got.word_value !== want.word_value)
                    begin
                        $error("word_value mismatch: expected 0x%02h, got 0x%02h",
                               want.word_value, got.word_value);
                        failures++;
                    end
                    if (got.parity_error !== want.parity_error)
                    begin
                        $error("parity_error mismatch: expected %0d, got %0d",
                               want.parity_error, got.parity_error);
                        failures++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last mismatch: expected %0d, got %0d", want.last, got.last);
                        failures++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:
                    begin
                        mode_reg = cfg_data[0];
                        bit_cnt  = 0;
                    end
                    CFG_WORDS:
                    begin
                        words_reg = cfg_data;
                        bit_cnt   = 0;
                    end
                    CFG_BITS:
                    begin
                        bits_reg = cfg_data[2:0];
                        bit_cnt  = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (start && !busy)
            begin
                wc  = (words_reg == 0) ? 1 : ((words_reg > 8) ? 8 : int'(words_reg));
                db  = (bits_reg == 0) ? 1 : int'(bits_reg);
                len = db + 1;
                if (mode_reg == MODE_SEND)
                begin
                    total = wc * db;
                    row   = bit_cnt / db;
                    col   = bit_cnt % db;
                end
                else
                begin
                    total = wc * len;
                    row   = bit_cnt % wc;
                    col   = bit_cnt / wc;
                end
                row_store[row][col] = bit_in;
                bit_cnt = (bit_cnt + 1) & 8'h7f;
                if (bit_cnt >= total)
                begin
                    bit_cnt = 0;
                    if (mode_reg == MODE_SEND)
                    begin
                        // odd parity goes in the column after the data bits
                        for (int j = 0; j < wc; j++)
                        begin
                            par = 1'b1;
                            for (int k = 0; k < db; k++)
                            begin
                                par ^= row_store[j][k];
                            end
                            row_store[j][db] = par;
                        end
                        for (int i = 0; i < len; i++)
                        begin
                            for (int j = 0; j < wc; j++)
                            begin
                                block_out_q.push_back('{row_store[j][i], 8'd0, 1'b0,
                                                        (i == len - 1) && (j == wc - 1)});
                            end
                        end
                    end
                    else
                    begin
                        for (int j = 0; j < wc; j++)
                        begin
                            word = '0;
                            par  = 1'b1;
                            for (int i = 0; i < len; i++)
                            begin
                                word = {word[6:0], row_store[j][i]};
                                par ^= row_store[j][i];
                            end
                            block_out_q.push_back('{1'b0, word, par, j == wc - 1});
                        end
                    end
                end
            end

            waiting = block_out_q.size();
        end
    end

endmodule

// ===== verif/tb_odd_parity_block_interleaver.sv =====
module tb_odd_parity_block_interleaver;

    import opbi_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE     = 16;
    localparam int STALL_MAX  = 2000;
    localparam int ITEM_GOAL  = 300;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       bit_in;
    logic       out_valid;
    logic       bit_out;
    logic [7:0] word_value;
    logic       parity_error;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    int mon_failures;
    int mon_waiting;
    int mon_checked;

    int  items_sent;
    int  reg_writes;
    int  stall_cycles = 0;
    bit  no_gaps;

    odd_parity_block_interleaver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .bit_in      (bit_in),
        .out_valid   (out_valid),
        .bit_out     (bit_out),
        .word_value  (word_value),
        .parity_error(parity_error),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    opbi_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .bit_in      (bit_in),
        .out_valid   (out_valid),
        .bit_out     (bit_out),
        .word_value  (word_value),
        .parity_error(parity_error),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (mon_failures),
        .waiting     (mon_waiting),
        .checked     (mon_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("odd_parity_block_interleaver verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_bit(input logic b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        bit_in <= b;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // hold off until all pending items are out and the input queue has drained
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (mon_waiting != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_cfg(input logic m, input logic [3:0] w, input logic [2:0] b);
        write_reg(CFG_MODE, {3'b000, m});
        write_reg(CFG_WORDS, w);
        write_reg(CFG_BITS, {1'b0, b});
    endtask

    initial
    begin
        logic       m;
        logic [3:0] w;
        logic [2:0] b;
        int         wc;
        int         db;
        int         len;
        int         phase;

        rst_n        = 1'b0;
        start        = 1'b0;
        bit_in       = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MODE;
        cfg_data     = '0;
        items_sent   = 0;
        reg_writes   = 0;
        no_gaps      = 1'b0;
        phase        = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // zero word count and zero data bits act as one
        set_cfg(MODE_SEND, 4'd0, 3'd0);
        send_bit(1'b1);
        send_bit(1'b0);
        quiesce();
        set_cfg(MODE_RECV, 4'd0, 3'd0);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        quiesce();

        // word count above the maximum saturates
        set_cfg(MODE_SEND, 4'd15, 3'd1);
        no_gaps = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            send_bit(k[0] ^ k[2]);
        end
        no_gaps = 1'b0;
        quiesce();

        // unknown register index keeps the partial block, a real write drops it
        set_cfg(MODE_SEND, 4'd1, 3'd2);
        send_bit(1'b1);
        quiesce();
        write_reg(CFG_UNUSED, 4'hf);
        send_bit(1'b0);
        quiesce();
        send_bit(1'b1);
        quiesce();
        write_reg(CFG_BITS, 4'd2);
        send_bit(1'b1);
        send_bit(1'b1);
        quiesce();

        while (items_sent < ITEM_GOAL)
        begin
            m = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0:       w = 4'd0;
                1:       w = 4'($urandom_range(9, 15));
                2:       w = 4'd8;
                default: w = 4'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 7))
                0:       b = 3'd0;
                1:       b = 3'd7;
                default: b = 3'($urandom_range(1, 4));
            endcase
            if (phase == 0)
            begin
                m = MODE_SEND;
                w = 4'd8;
                b = 3'd7;
            end
            else if (phase == 1)
            begin
                m = MODE_RECV;
                w = 4'd8;
                b = 3'd7;
            end
            set_cfg(m, w, b);

            wc  = (w == 0) ? 1 : ((w > 8) ? 8 : int'(w));
            db  = (b == 0) ? 1 : int'(b);
            len = (m == MODE_SEND) ? wc * db : wc * (db + 1);
            no_gaps = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(1, 3))
            begin
                for (int k = 0; k < len; k++)
                begin
                    send_bit(1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    quiesce();
                end
            end
            // occasionally leave a block unfinished for the next write to drop
            if (len > 1 && $urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, len - 1)) send_bit(1'($urandom_range(0, 1)));
            end
            quiesce();
            phase++;
        end

        $display("run covered %0d serial bits in send and receive modes over %0d phases",
                 items_sent, phase + 4);
        $display("%0d register writes, %0d result items compared", reg_writes, mon_checked);
        if (mon_failures == 0 && mon_waiting == 0)
        begin
            $display("odd_parity_block_interleaver verification clean");
        end
        else
        begin
            $display("odd_parity_block_interleaver verification failed");
        end
        $finish;
    end

endmodule
